// ----- hw/rtl/wmo_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and codes for the wavetable mix oscillator
package wmo_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int NUM_WAVES       = 4;
    localparam int FRAC_W          = 16;   // phase fraction bits
    localparam int LEVEL_SHIFT     = 24;   // Q1.24 levels

    localparam int FUNC_W   = 2;
    localparam int SEL_W    = 2;
    localparam int ADDR_W   = 10;
    localparam int SMP_W    = 16;
    localparam int OUT_W    = 18;
    localparam int STEP_W   = 26;
    localparam int LVL_W    = 25;
    localparam int COEF_W   = 24;
    localparam int BAND_W   = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 26;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SINE_TARGET     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_TARGET   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAW_TARGET      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIANGLE_TARGET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_COEF  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_BAND     = 3'd6;

    localparam logic [COEF_W-1:0] COEF_RST = 24'd3804;
    localparam logic [BAND_W-1:0] BAND_RST = 16'd38;

    // input function codes
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_NOTE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd2;

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // read sequence: lower and upper neighbour for each wave
    localparam int CNT_W = $clog2(2 * NUM_WAVES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(2 * NUM_WAVES - 1);

    typedef enum logic [1:0] {
        OP_SAMPLE,
        OP_NOTE,
        OP_WRITE
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic [SEL_W-1:0]        sel;
        logic [ADDR_W-1:0]       addr;
        logic [SMP_W-1:0]        value;
    } t_cmd;

    typedef struct packed {
        logic [STEP_W-1:0]                 phase_step;
        logic [NUM_WAVES-1:0][LVL_W-1:0]   target;
        logic [COEF_W-1:0]                 coef;
        logic [BAND_W-1:0]                 band;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_RESULT,
        ST_WRAP
    } t_bstate;

endpackage

// ----- hw/rtl/wavetable_mix_oscillator_core.sv -----
`timescale 1ns / 1ps
// top level of the wavetable mix oscillator: config registers, front and back ends
//
//   channel   direction   handshake                 payload
//   cfg       in          i_cfg_we                  i_cfg_index, i_cfg_data
//   in        in          i_in_valid / o_in_stall   i_func, i_table_select, i_table_addr,
//                                                   i_table_value
//   out       out         o_out_valid / i_out_stall o_mixed_sample
//
// a table write or note on is taken and finished by the back end in its idle state
// a sample is taken, then eight reads go through the single table ram port, the
// glide/interp/weight/accumulate pipe drains, the result is loaded, then the phase wraps,
// one compare-subtract per cycle (2 steps at depth 1024); a result still held by a
// stalled output delays the load
// a two-entry command queue lets the input side keep moving while the back end works
// synchronous active-low reset clears the phase, levels and queue; tables are not cleared
module wavetable_mix_oscillator_core import wmo_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [FUNC_W-1:0]       i_func,
    input  logic [SEL_W-1:0]        i_table_select,
    input  logic [ADDR_W-1:0]       i_table_addr,
    input  logic signed [SMP_W-1:0] i_table_value,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [OUT_W-1:0] o_mixed_sample
);

    t_cfg r_cfg;
    t_cmd cmd;
    logic cmd_valid;
    logic cmd_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step <= '0;
            r_cfg.target     <= '0;
            r_cfg.coef       <= COEF_RST;
            r_cfg.band       <= BAND_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PHASE_STEP:      r_cfg.phase_step <= i_cfg_data[STEP_W-1:0];
                CFG_SINE_TARGET:     r_cfg.target[0]  <= i_cfg_data[LVL_W-1:0];
                CFG_SQUARE_TARGET:   r_cfg.target[1]  <= i_cfg_data[LVL_W-1:0];
                CFG_SAW_TARGET:      r_cfg.target[2]  <= i_cfg_data[LVL_W-1:0];
                CFG_TRIANGLE_TARGET: r_cfg.target[3]  <= i_cfg_data[LVL_W-1:0];
                CFG_SMOOTHING_COEF:  r_cfg.coef       <= i_cfg_data[COEF_W-1:0];
                CFG_SETTLE_BAND:     r_cfg.band       <= i_cfg_data[BAND_W-1:0];
                default: begin
                end
            endcase
        end
    end

    wmo_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_table_select (i_table_select),
        .i_table_addr   (i_table_addr),
        .i_table_value  (i_table_value),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd),
        .i_cmd_take     (cmd_take)
    );

    wmo_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_cmd_valid    (cmd_valid),
        .i_cmd          (cmd),
        .o_cmd_take     (cmd_take),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_mixed_sample (o_mixed_sample)
    );

endmodule

// ----- hw/rtl/wmo_ram.sv -----
`timescale 1ns / 1ps
// generic single write port ram with registered read
module wmo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/wmo_front.sv -----
`timescale 1ns / 1ps
// front end: takes input items, drops meaningless ones, queues commands
module wmo_front import wmo_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [SEL_W-1:0]  i_table_select,
    input  logic [ADDR_W-1:0] i_table_addr,
    input  logic [SMP_W-1:0]  i_table_value,
    output logic              o_cmd_valid,
    output t_cmd              o_cmd,
    input  logic              i_cmd_take
);

    t_cmd              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic accept;
    logic keep;
    logic pop;
    t_cmd cmd_in;

    always_comb begin
        keep         = 1'b0;
        cmd_in.op    = OP_SAMPLE;
        cmd_in.sel   = i_table_select;
        cmd_in.addr  = i_table_addr;
        cmd_in.value = i_table_value;
        unique case (i_func)
            FUNC_SAMPLE: begin
                keep = 1'b1;
            end
            FUNC_NOTE: begin
                keep      = 1'b1;
                cmd_in.op = OP_NOTE;
            end
            FUNC_WRITE: begin
                // writes beyond the table are dropped here
                keep      = 32'(i_table_addr) < TABLE_DEPTH;
                cmd_in.op = OP_WRITE;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_in_stall  = (r_count == QCNT_W'(QDEPTH));
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign pop         = i_cmd_take && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (accept && keep) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if ((accept && keep) && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (!(accept && keep) && pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && keep) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

// ----- hw/rtl/wmo_back.sv -----
`timescale 1ns / 1ps
// back end: table writes, level glide, interpolated lookup, mix and phase advance
module wmo_back import wmo_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_cmd_valid,
    input  t_cmd                    i_cmd,
    output logic                    o_cmd_take,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [OUT_W-1:0] o_mixed_sample
);

    localparam int IDX_W     = $clog2(TABLE_DEPTH);
    localparam int PH_W      = IDX_W + FRAC_W;
    localparam int MEM_DEPTH = NUM_WAVES * TABLE_DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int SUM_W     = ((PH_W > STEP_W) ? PH_W : STEP_W) + 1;
    localparam int RED_SH    = SUM_W - PH_W;
    localparam int RED_W     = SUM_W + 1;
    localparam int RCNT_W    = $clog2(RED_SH + 1);
    localparam int D_W       = LVL_W + 1;
    localparam int GP_W      = D_W + COEF_W + 1;
    localparam int IP_W      = 2 * (SMP_W + 1);
    localparam int WP_W      = LVL_W + 1 + SMP_W;
    localparam int ACC_W     = WP_W + 2;
    localparam int SH_W      = ACC_W - LEVEL_SHIFT;

    localparam logic [RED_W-1:0]  MOD_TOP   = RED_W'(TABLE_DEPTH) << (FRAC_W + RED_SH);
    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [RCNT_W-1:0] RCNT_TOP  = RCNT_W'(RED_SH);
    localparam logic [AW-1:0]     WAVE_SPAN = AW'(TABLE_DEPTH);

    t_bstate r_state;
    t_bstate n_state;

    logic [PH_W-1:0]   r_phase;
    logic [LVL_W-1:0]  r_level [NUM_WAVES];
    logic [CNT_W-1:0]  r_cnt;
    logic [RED_W-1:0]  r_red;
    logic [RED_W-1:0]  r_modc;
    logic [RCNT_W-1:0] r_rcnt;

    logic                 r_s1_vld;
    logic                 r_s1_hi;
    logic [SEL_W-1:0]     r_s1_wave;
    logic                 r_s2_vld;
    logic                 r_s3_vld;

    logic signed [D_W-1:0]   r_gd;
    logic                    r_gmove;
    logic [LVL_W-1:0]        r_glvl;
    logic signed [GP_W-1:0]  r_gprod;
    logic signed [SMP_W-1:0] r_lo;
    logic signed [SMP_W-1:0] r_ilo;
    logic signed [IP_W-1:0]  r_iprod;
    logic [LVL_W-1:0]        r_nlvl;
    logic signed [WP_W-1:0]  r_wprod;
    logic signed [ACC_W-1:0] r_acc;

    logic                    r_out_vld;
    logic signed [OUT_W-1:0] r_out_data;

    // sequencer strobes
    logic cmd_take;
    logic ram_we;
    logic issue;
    logic start;
    logic note;
    logic load_out;
    logic wrap_step;

    logic [SMP_W-1:0] rdata;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;

    logic [SEL_W-1:0] iss_wave;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] nxt;
    logic [IDX_W-1:0] rd_idx;

    logic signed [D_W-1:0]   g_d;
    logic [D_W-1:0]          g_mag;
    logic signed [LVL_W+1:0] g_sum;
    logic [LVL_W-1:0]        g_new;
    logic signed [SMP_W:0]   i_diff;
    logic signed [SMP_W+1:0] v_sum;
    logic signed [SH_W-1:0]  acc_sh;
    logic signed [OUT_W-1:0] sat;
    logic                    red_ge;
    logic [RED_W-1:0]        red_nx;

    // state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        cmd_take  = 1'b0;
        ram_we    = 1'b0;
        issue     = 1'b0;
        start     = 1'b0;
        note      = 1'b0;
        load_out  = 1'b0;
        wrap_step = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    cmd_take = 1'b1;
                    unique case (i_cmd.op)
                        OP_SAMPLE: begin
                            start   = 1'b1;
                            n_state = ST_ISSUE;
                        end
                        OP_NOTE: begin
                            note = 1'b1;
                        end
                        OP_WRITE: begin
                            ram_we = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ISSUE: begin
                issue = 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_s1_vld && !r_s2_vld && !r_s3_vld) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!r_out_vld || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = ST_WRAP;
                end
            end
            ST_WRAP: begin
                wrap_step = 1'b1;
                if (r_rcnt == '0) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_cmd_take = cmd_take;

    // table ram, one port serves all eight neighbour reads
    assign waddr    = AW'(i_cmd.sel) * WAVE_SPAN + AW'(i_cmd.addr);
    assign iss_wave = r_cnt[CNT_W-1:1];
    assign idx      = r_phase[PH_W-1:FRAC_W];
    assign nxt      = (idx == IDX_LAST) ? '0 : idx + 1'b1;
    assign rd_idx   = r_cnt[0] ? nxt : idx;
    assign raddr    = AW'(iss_wave) * WAVE_SPAN + AW'(rd_idx);

    wmo_ram #(
        .WIDTH (SMP_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata (i_cmd.value),
        .i_re    (issue),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // glide distance for the wave whose lower neighbour is issued
    assign g_d   = $signed({1'b0, i_cfg.target[iss_wave]}) - $signed({1'b0, r_level[iss_wave]});
    assign g_mag = g_d[D_W-1] ? D_W'(-g_d) : D_W'(g_d);

    // floor shift by taking the upper product bits
    assign g_sum = $signed({2'b00, r_glvl}) + $signed(r_gprod[GP_W-1 -: LVL_W+2]);
    assign g_new = r_gmove ? g_sum[LVL_W-1:0] : r_glvl;

    assign i_diff = $signed({rdata[SMP_W-1], rdata}) - $signed({r_lo[SMP_W-1], r_lo});
    assign v_sum  = $signed({{2{r_ilo[SMP_W-1]}}, r_ilo}) + r_iprod[IP_W-1 -: SMP_W+2];

    // mix scaling and saturation
    assign acc_sh = r_acc[ACC_W-1:LEVEL_SHIFT];
    always_comb begin
        if (acc_sh[SH_W-1:OUT_W-1] == '0 || acc_sh[SH_W-1:OUT_W-1] == '1) begin
            sat = acc_sh[OUT_W-1:0];
        end else if (acc_sh[SH_W-1]) begin
            sat = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            sat = {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    assign red_ge = (r_red >= r_modc);
    assign red_nx = red_ge ? r_red - r_modc : r_red;

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_cnt     <= '0;
            r_rcnt    <= '0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k < NUM_WAVES; k++) begin
                r_level[k] <= '0;
            end
        end else begin
            if (start) begin
                r_cnt <= '0;
            end else if (issue) begin
                r_cnt <= r_cnt + 1'b1;
            end
            r_s1_vld <= issue;
            r_s2_vld <= r_s1_vld && r_s1_hi;
            r_s3_vld <= r_s2_vld;
            // new level is written back when the upper neighbour's read reaches stage 1
            if (r_s1_vld && r_s1_hi) begin
                r_level[r_s1_wave] <= g_new;
            end
            if (note) begin
                r_phase <= '0;
            end else if (wrap_step && r_rcnt == '0) begin
                r_phase <= red_nx[PH_W-1:0];
            end
            if (load_out) begin
                r_rcnt <= RCNT_TOP;
            end else if (wrap_step) begin
                r_rcnt <= r_rcnt - 1'b1;
            end
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_s1_hi   <= r_cnt[0];
        r_s1_wave <= iss_wave;
        if (issue && !r_cnt[0]) begin
            r_gd    <= g_d;
            r_gmove <= g_mag > D_W'(i_cfg.band);
            r_glvl  <= r_level[iss_wave];
        end
        if (r_s1_vld && !r_s1_hi) begin
            r_lo    <= rdata;
            r_gprod <= r_gd * $signed({1'b0, i_cfg.coef});
        end
        if (r_s1_vld && r_s1_hi) begin
            r_iprod <= i_diff * $signed({1'b0, r_phase[FRAC_W-1:0]});
            r_ilo   <= r_lo;
            r_nlvl  <= g_new;
        end
        if (r_s2_vld) begin
            r_wprod <= $signed({1'b0, r_nlvl}) * $signed(v_sum[SMP_W-1:0]);
        end
        if (start) begin
            r_acc <= '0;
        end else if (r_s3_vld) begin
            r_acc <= r_acc + ACC_W'(r_wprod);
        end
        if (load_out) begin
            r_out_data <= sat;
            r_red      <= RED_W'(r_phase) + RED_W'(i_cfg.phase_step);
            r_modc     <= MOD_TOP;
        end else if (wrap_step) begin
            r_red  <= red_nx;
            r_modc <= r_modc >> 1;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_mixed_sample = r_out_data;

endmodule

// ----- hw/rtl/wmo_checker.sv -----
`timescale 1ns / 1ps
// port-level checker for the wavetable mix oscillator, bound to the top level
module wmo_checker import wmo_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic [FUNC_W-1:0]       i_func,
    input logic [SEL_W-1:0]        i_table_select,
    input logic [ADDR_W-1:0]       i_table_addr,
    input logic signed [SMP_W-1:0] i_table_value,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic signed [OUT_W-1:0] o_mixed_sample
);

    // a result waiting on a stall stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // and keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_mixed_sample))
        else $error("stalled result changed");

    // a stalled input transfer stays offered with the same payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=>
            i_in_valid && $stable({i_func, i_table_select, i_table_addr, i_table_value}))
        else $error("stalled input changed");

    // reset leaves no stale result and an open input
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

endmodule

bind wavetable_mix_oscillator_core wmo_checker u_wmo_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_func         (i_func),
    .i_table_select (i_table_select),
    .i_table_addr   (i_table_addr),
    .i_table_value  (i_table_value),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_mixed_sample (o_mixed_sample)
);
